FILE: hw/rtl/stm_pkg.sv
package stm_pkg;

    // Sample format: Q1.15 two's complement.
    localparam int unsigned SampleBits = 16;
    localparam int unsigned MagBits    = SampleBits - 1;

    // Defaults for the top-level parameters.
    localparam int unsigned MAX_CHANNELS    = 8;
    localparam int unsigned SINE_TABLE_BITS = 10;

    // Configuration register widths.
    localparam int unsigned CfgCountBits = 4;
    localparam int unsigned CfgStepBits  = 31;
    localparam int unsigned CfgAmpBits   = 16;
    localparam int unsigned CfgDataBits  = 31;
    localparam int unsigned CfgIdxBits   = 2;

    // Configuration register indexes.
    localparam logic [CfgIdxBits-1:0] RegEnable       = 2'd0;
    localparam logic [CfgIdxBits-1:0] RegPhaseStep    = 2'd1;
    localparam logic [CfgIdxBits-1:0] RegAmplitude    = 2'd2;
    localparam logic [CfgIdxBits-1:0] RegChannelCount = 2'd3;

    // Width of the phase accumulator.
    localparam int unsigned PhaseBits = 32;

    // Pi/2 in Q30.
    localparam longint unsigned HalfPiQ30 = 64'd1686629713;

    // Unsigned long division by shift and subtract, used only while the
    // design elaborates.
    function automatic longint unsigned div_u64(
        input longint unsigned num,
        input longint unsigned den
    );
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            if (r >= den) begin
                r    = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Full-scale sine value for one quarter-wave entry, evaluated while the
    // design elaborates: Q30 angle, odd Taylor terms to t^11 with each term
    // truncated, scaled to the sample range and rounded half up.
    function automatic logic [MagBits-1:0] quarter_sine(
        input int unsigned k,
        input int unsigned quarter_bits
    );
        longint unsigned n;
        longint unsigned x;
        longint unsigned t;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned v;
        longint unsigned smax;
        longint unsigned kk;
        longint unsigned dv;
        n    = 64'd1 << quarter_bits;
        smax = (64'd1 << (SampleBits - 1)) - 64'd1;
        kk   = 64'(k);
        if (kk > n) begin
            kk = n;
        end
        x    = kk << (30 - quarter_bits);
        t    = (x * HalfPiQ30) >> 30;
        term = t;
        sum  = t;
        for (int i = 1; i <= 5; i++) begin
            term = (term * t) >> 30;
            term = (term * t) >> 30;
            dv   = 64'((2 * i) * (2 * i + 1));
            term = div_u64(term, dv);
            if ((i & 1) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        v = (sum * smax + (64'd1 << 29)) >> 30;
        if (v > smax) begin
            v = smax;
        end
        return v[MagBits-1:0];
    endfunction

endpackage

FILE: hw/rtl/sine_tone_mixer.sv
// Sine tone mixer: adds a direct digital synthesis sine tone to a stream of
// interleaved Q1.15 PCM samples. While the enable register is 1, every sample
// of a frame (channel_count samples, clamped to 1..MAX_CHANNELS) gets the same
// tone value added, and the sum saturates to 16 bits with the clipped flag
// (tuser) raised when it does. The tone is amplitude times the sine of a
// 32-bit phase accumulator that advances by phase_step once per frame; its
// top SINE_TABLE_BITS bits address a quarter-wave table of
// 2^(SINE_TABLE_BITS-2) entries. Writing enable from 0 to 1 restarts the
// phase at zero and the frame at its first channel; while disabled, samples
// pass through unchanged and the phase is held. The block takes one sample
// per clock cycle while the output is not stalled and registers the result
// at acceptance; table read, gain multiplier and saturating add are all
// combinational in front of the output register. Configuration is to be
// written only while no transaction is in flight; the block does not check.
module sine_tone_mixer #(
    parameter int unsigned MAX_CHANNELS    = stm_pkg::MAX_CHANNELS,
    parameter int unsigned SINE_TABLE_BITS = stm_pkg::SINE_TABLE_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    // Configuration write port.
    input  logic                                i_cfg_we,
    input  logic [stm_pkg::CfgIdxBits-1:0]      i_cfg_index,
    input  logic [stm_pkg::CfgDataBits-1:0]     i_cfg_data,

    // Input stream. tdata: [15:0] sample_in.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [stm_pkg::SampleBits-1:0]      s_axis_tdata,

    // Output stream. tdata: [15:0] sample_out. tuser: [0] clipped.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [stm_pkg::SampleBits-1:0]      m_axis_tdata,
    output logic                                m_axis_tuser
);

    localparam int unsigned SB    = stm_pkg::SampleBits;
    localparam int unsigned MB    = stm_pkg::MagBits;
    localparam int unsigned PB    = stm_pkg::PhaseBits;
    localparam int unsigned QB    = SINE_TABLE_BITS - 2;
    localparam int unsigned NQ    = 1 << QB;
    localparam int unsigned PW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int unsigned MCW   = $clog2(MAX_CHANNELS + 1);
    localparam int unsigned CNTW  = (MCW > stm_pkg::CfgCountBits) ? MCW
                                                                  : stm_pkg::CfgCountBits;
    localparam int unsigned AB    = stm_pkg::CfgAmpBits;
    localparam int unsigned PRODW = 2 * AB;
    localparam logic [MB-1:0] TableTop = stm_pkg::quarter_sine(NQ, QB);
    localparam logic [MB-1:0] SMax     = {MB{1'b1}};

    // Configuration registers.
    logic                            r_enable;
    logic [stm_pkg::CfgStepBits-1:0] r_phase_step;
    logic [AB-1:0]                   r_amplitude;
    logic [stm_pkg::CfgCountBits-1:0] r_channel_count;

    // Oscillator state.
    logic [PB-1:0]        r_phase;
    logic [PW-1:0]        r_pos;
    logic signed [SB-1:0] r_held_tone;

    // Output register.
    logic                 r_out_valid;
    logic [SB-1:0]        r_out_data;
    logic                 r_out_clip;

    // Quarter-wave table, built from constants at elaboration.
    logic [MB-1:0] w_table [NQ];

    for (genvar g = 0; g < NQ; g++) begin : g_table
        localparam logic [MB-1:0] Entry = stm_pkg::quarter_sine(g, QB);
        assign w_table[g] = Entry;
    end

    logic                    accept;
    logic [SINE_TABLE_BITS-1:0] idx;
    logic [1:0]              quadrant;
    logic [QB-1:0]           k;
    logic [QB-1:0]           k_mirror;
    logic [MB-1:0]           sine_mag;
    logic [PRODW-1:0]        prod;
    logic [PRODW-1:0]        prod_rnd;
    logic [PRODW-16:0]       tone_mag_full;
    logic [MB-1:0]           tone_mag;
    logic signed [SB-1:0]    new_tone;
    logic [CNTW-1:0]         cnt_raw;
    logic [CNTW-1:0]         cnt_eff;
    logic [PW-1:0]           pos_cur;
    logic [CNTW-1:0]         pos_inc;
    logic [PW-1:0]           n_pos;
    logic                    frame_start;
    logic signed [SB-1:0]    tone_cur;
    logic signed [SB:0]      sum;
    logic [SB-1:0]           n_out_data;
    logic                    n_out_clip;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !r_out_valid || m_axis_tready;

    // Tone for the current phase: quadrant mirror, table read, gain, round.
    always_comb begin
        idx      = r_phase[PB-1 -: SINE_TABLE_BITS];
        quadrant = idx[SINE_TABLE_BITS-1 -: 2];
        k        = idx[QB-1:0];
        k_mirror = QB'(~k + 1'b1);
        if (quadrant[0] && (k == '0)) begin
            sine_mag = TableTop;
        end else if (quadrant[0]) begin
            sine_mag = w_table[k_mirror];
        end else begin
            sine_mag = w_table[k];
        end
        prod          = PRODW'(sine_mag) * PRODW'(r_amplitude);
        prod_rnd      = prod + PRODW'(16384);
        tone_mag_full = prod_rnd[PRODW-1:15];
        if (tone_mag_full > (PRODW-15)'(SMax)) begin
            tone_mag = SMax;
        end else begin
            tone_mag = tone_mag_full[MB-1:0];
        end
        if (quadrant[1]) begin
            new_tone = -$signed({1'b0, tone_mag});
        end else begin
            new_tone = $signed({1'b0, tone_mag});
        end
    end

    // Frame position: clamp the channel count and wrap the position.
    always_comb begin
        cnt_raw = CNTW'(r_channel_count);
        if (cnt_raw == '0) begin
            cnt_eff = CNTW'(1);
        end else if (cnt_raw > CNTW'(MAX_CHANNELS)) begin
            cnt_eff = CNTW'(MAX_CHANNELS);
        end else begin
            cnt_eff = cnt_raw;
        end
        if (CNTW'(r_pos) >= cnt_eff) begin
            pos_cur = '0;
        end else begin
            pos_cur = r_pos;
        end
        frame_start = (pos_cur == '0);
        pos_inc     = CNTW'(pos_cur) + CNTW'(1);
        if (pos_inc >= cnt_eff) begin
            n_pos = '0;
        end else begin
            n_pos = pos_inc[PW-1:0];
        end
        tone_cur = frame_start ? new_tone : r_held_tone;
    end

    // Saturating mix, or pass-through while disabled.
    always_comb begin
        sum = $signed({s_axis_tdata[SB-1], s_axis_tdata}) + $signed({tone_cur[SB-1], tone_cur});
        if (!r_enable) begin
            n_out_data = s_axis_tdata;
            n_out_clip = 1'b0;
        end else if (sum[SB] != sum[SB-1]) begin
            n_out_data = sum[SB] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
            n_out_clip = 1'b1;
        end else begin
            n_out_data = sum[SB-1:0];
            n_out_clip = 1'b0;
        end
    end

    // Configuration registers and oscillator state. A configuration write must
    // not coincide with a transaction (not enforced here); if it does, its clearing wins.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable        <= 1'b0;
            r_phase_step    <= '0;
            r_amplitude     <= '0;
            r_channel_count <= stm_pkg::CfgCountBits'(2);
            r_phase         <= '0;
            r_pos           <= '0;
            r_held_tone     <= '0;
        end else begin
            if (accept && r_enable) begin
                r_pos <= n_pos;
                if (frame_start) begin
                    r_held_tone <= new_tone;
                    r_phase     <= r_phase + PB'(r_phase_step);
                end
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    stm_pkg::RegEnable: begin
                        if (i_cfg_data[0] && !r_enable) begin
                            r_phase <= '0;
                            r_pos   <= '0;
                        end
                        r_enable <= i_cfg_data[0];
                    end
                    stm_pkg::RegPhaseStep: begin
                        r_phase_step <= i_cfg_data[stm_pkg::CfgStepBits-1:0];
                    end
                    stm_pkg::RegAmplitude: begin
                        r_amplitude <= i_cfg_data[AB-1:0];
                    end
                    stm_pkg::RegChannelCount: begin
                        r_channel_count <= i_cfg_data[stm_pkg::CfgCountBits-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Output register: holds a result until the downstream side takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= n_out_data;
            r_out_clip <= n_out_clip;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_clip;

endmodule
